### sv/assert_macros.svh
// Assertion macros shared by the path aggregation RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SGMDP_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent holds in the cycle after the antecedent.
`define SGMDP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### sv/sgmdp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the diagonal path cost aggregation block.
// No dependencies.
package sgmdp_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_DISP = 64;
    localparam int COL_W = 10;
    localparam int DISP_W = 6;
    localparam int HALF_W = DISP_W - 1;
    localparam int COST_W = 13;
    localparam int BANK_AW = 1 + COL_W + HALF_W;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int STAT_AW = 1 + COL_W;
    localparam int STAT_DEPTH = 1 << STAT_AW;
    localparam int STAT_W = 2 * COST_W + DISP_W;

    localparam logic [COST_W-1:0] COST_ALL_ONES = {COST_W{1'b1}};

    localparam logic [2:0] REG_P1 = 3'd0;
    localparam logic [2:0] REG_P2 = 3'd1;
    localparam logic [2:0] REG_FRAME_ROWS = 3'd2;
    localparam logic [2:0] REG_FRAME_COLS = 3'd3;
    localparam logic [2:0] REG_DISP_COUNT = 3'd4;
    localparam logic [2:0] REG_ROW_DOWN = 3'd5;
    localparam logic [2:0] REG_COL_RIGHT = 3'd6;

    typedef struct packed {
        logic [11:0] frame_rows;
        logic [10:0] frame_cols;
        logic [6:0]  disp_count;
        logic        row_down;
        logic        col_right;
    } scan_cfg_t;

    typedef struct packed {
        logic [7:0]        cost;
        logic [DISP_W-1:0] disp;
        logic              slot;
        logic [COL_W-1:0]  col;
        logic              first;
        logic              has_next;
        logic              multi;
        logic              last_pixel;
        logic              last_frame;
        logic [11:0]       pix_row;
        logic [COL_W-1:0]  pix_col;
    } item_t;

endpackage

### sv/sgm_diagonal_path_aggregation_core.sv
`timescale 1ns / 1ps
// Top level of the diagonal path cost aggregation block.
// Depends on sgmdp_pkg, sgmdp_front, sgmdp_queue, sgmdp_back and assert_macros.svh.

// The block takes one matching cost per cycle while in_stall is low and
// returns one path cost per cost, in order. Each item passes through the
// two-entry queue, the s1 stage register with the store reads, and the
// output registers. Sustained rate is one item per clock when the output is
// not stalled, set by the two banked path cost stores (even and odd
// disparities), which deliver the predecessor's costs at d and d+1 in a
// single read cycle, while d-1 is kept from the previous item. Per-pixel
// minimum statistics come from a separate store read once per item. Stores
// are not cleared after reset; the first scanned row and column ignore what they read.
`include "assert_macros.svh"

module sgm_diagonal_path_aggregation_core
    import sgmdp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         match_cost,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COST_W-1:0]  path_cost,
    output logic [DISP_W-1:0]  disparity,
    output logic [11:0]        pixel_row,
    output logic [COL_W-1:0]   pixel_col,
    output logic               last_of_pixel,
    output logic               last_of_frame
);

    logic [7:0]  p1_reg;
    logic [11:0] p2_reg;
    scan_cfg_t   scan_cfg_reg;
    logic        q_full;
    logic        q_push;
    item_t       q_push_item;
    logic        q_pop;
    logic        q_head_valid;
    item_t       q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= 8'd10;
            p2_reg <= 12'd120;
            scan_cfg_reg.frame_rows <= 12'd480;
            scan_cfg_reg.frame_cols <= 11'd640;
            scan_cfg_reg.disp_count <= 7'd64;
            scan_cfg_reg.row_down <= 1'b1;
            scan_cfg_reg.col_right <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_P1:         p1_reg <= cfg_data[7:0];
                REG_P2:         p2_reg <= cfg_data;
                REG_FRAME_ROWS: scan_cfg_reg.frame_rows <= cfg_data;
                REG_FRAME_COLS: scan_cfg_reg.frame_cols <= cfg_data[10:0];
                REG_DISP_COUNT: scan_cfg_reg.disp_count <= cfg_data[6:0];
                REG_ROW_DOWN:   scan_cfg_reg.row_down <= cfg_data[0];
                REG_COL_RIGHT:  scan_cfg_reg.col_right <= cfg_data[0];
                default:        p1_reg <= p1_reg;
            endcase
        end
    end

    sgmdp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (scan_cfg_reg),
        .in_valid   (in_valid),
        .match_cost (match_cost),
        .q_full     (q_full),
        .in_stall   (in_stall),
        .push       (q_push),
        .push_item  (q_push_item)
    );

    sgmdp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    sgmdp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .p1            (p1_reg),
        .p2            (p2_reg),
        .head_valid    (q_head_valid),
        .head          (q_head),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .path_cost     (path_cost),
        .disparity     (disparity),
        .pixel_row     (pixel_row),
        .pixel_col     (pixel_col),
        .last_of_pixel (last_of_pixel),
        .last_of_frame (last_of_frame)
    );

    `SGMDP_ASSERT_IMPLY(a_frame_end_ends_pixel, out_valid && last_of_frame, last_of_pixel)
    `SGMDP_ASSERT_IMPLY(a_no_push_when_full, q_full, !q_push)
    `SGMDP_ASSERT_NEXT(a_pop_fills_back, q_pop, q_full == 1'b0)

endmodule

### sv/sgmdp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module sgmdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/sgmdp_front.sv
`timescale 1ns / 1ps
// Front end: accepts costs, tracks the scan position and classifies each item.
// Depends on sgmdp_pkg.
module sgmdp_front
    import sgmdp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  scan_cfg_t cfg,
    input  logic      in_valid,
    input  logic [7:0] match_cost,
    input  logic      q_full,
    output logic      in_stall,
    output logic      push,
    output item_t     push_item
);

    logic [11:0]       row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [DISP_W-1:0] disp_reg, disp_next;
    logic [11:0]       rows_c;
    logic [10:0]       cols_c;
    logic [6:0]        dcnt;
    logic [6:0]        d_inc;
    logic [10:0]       col_inc;
    logic [12:0]       row_inc;
    logic [10:0]       col_mirror;
    logic              last_pixel;
    logic              col_end;
    logic              row_end;

    always_comb
    begin
        rows_c = (cfg.frame_rows == 12'd0) ? 12'd1 : cfg.frame_rows;
        if (cfg.frame_cols == 11'd0)
        begin
            cols_c = 11'd1;
        end
        else if (cfg.frame_cols > 11'(MAX_COLS))
        begin
            cols_c = 11'(MAX_COLS);
        end
        else
        begin
            cols_c = cfg.frame_cols;
        end
        if (cfg.disp_count == 7'd0)
        begin
            dcnt = 7'd1;
        end
        else if (cfg.disp_count > 7'(MAX_DISP))
        begin
            dcnt = 7'(MAX_DISP);
        end
        else
        begin
            dcnt = cfg.disp_count;
        end
    end

    assign d_inc = {1'b0, disp_reg} + 7'd1;
    assign col_inc = {1'b0, col_reg} + 11'd1;
    assign row_inc = {1'b0, row_reg} + 13'd1;
    assign last_pixel = d_inc >= dcnt;
    assign col_end = col_inc >= cols_c;
    assign row_end = row_inc >= {1'b0, rows_c};
    assign col_mirror = cols_c - 11'd1 - {1'b0, col_reg};

    assign in_stall = q_full;
    assign push = in_valid && !q_full;

    always_comb
    begin
        push_item.cost = match_cost;
        push_item.disp = disp_reg;
        push_item.slot = row_reg[0];
        push_item.col = col_reg;
        push_item.first = (row_reg == 12'd0) || (col_reg == '0);
        push_item.has_next = !last_pixel;
        push_item.multi = dcnt > 7'd1;
        push_item.last_pixel = last_pixel;
        push_item.last_frame = last_pixel && col_end && row_end;
        push_item.pix_row = cfg.row_down ? row_reg : (rows_c - 12'd1 - row_reg);
        push_item.pix_col = cfg.col_right ? col_reg : col_mirror[COL_W-1:0];
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        disp_next = disp_reg;
        if (push)
        begin
            if (last_pixel)
            begin
                disp_next = '0;
                if (col_end)
                begin
                    col_next = '0;
                    row_next = row_end ? 12'd0 : row_inc[11:0];
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
            else
            begin
                disp_next = d_inc[DISP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            disp_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            disp_reg <= disp_next;
        end
    end

endmodule

### sv/sgmdp_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of classified items between the front and back ends.
// Depends on sgmdp_pkg.
module sgmdp_queue
    import sgmdp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  head_valid,
    output item_t head
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### sv/sgmdp_back.sv
`timescale 1ns / 1ps
// Back end: reads the previous row's path costs, computes each path cost and
// keeps the per-pixel minimum statistics. Depends on sgmdp_pkg and sgmdp_ram.
module sgmdp_back
    import sgmdp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         p1,
    input  logic [11:0]        p2,
    input  logic               head_valid,
    input  item_t              head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COST_W-1:0]  path_cost,
    output logic [DISP_W-1:0]  disparity,
    output logic [11:0]        pixel_row,
    output logic [COL_W-1:0]   pixel_col,
    output logic               last_of_pixel,
    output logic               last_of_frame
);

    item_t              s1_item_reg;
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_adv;
    logic [COST_W-1:0]  prev_dm1_reg;
    logic [COST_W-1:0]  run_min_reg, run_min_next;
    logic [COST_W-1:0]  run_sec_reg, run_sec_next;
    logic [DISP_W-1:0]  run_best_reg, run_best_next;
    logic               out_valid_reg, out_valid_next;
    logic [COST_W-1:0]  path_cost_reg;
    logic [DISP_W-1:0]  disparity_reg;
    logic [11:0]        pixel_row_reg;
    logic [COL_W-1:0]   pixel_col_reg;
    logic               last_pixel_reg;
    logic               last_frame_reg;

    logic [COL_W-1:0]   rd_col;
    logic [DISP_W:0]    rd_dn;
    logic [DISP_W:0]    even_e;
    logic [DISP_W:0]    odd_e;
    logic [BANK_AW-1:0] even_raddr;
    logic [BANK_AW-1:0] odd_raddr;
    logic [STAT_AW-1:0] stat_raddr;
    logic [COST_W-1:0]  even_q;
    logic [COST_W-1:0]  odd_q;
    logic [STAT_W-1:0]  stat_q;
    logic [BANK_AW-1:0] cost_waddr;
    logic [STAT_AW-1:0] stat_waddr;
    logic [STAT_W-1:0]  stat_wdata;

    logic [COST_W-1:0]  prev_d;
    logic [COST_W-1:0]  prev_dp1;
    logic [COST_W-1:0]  pmin;
    logic [COST_W-1:0]  psec;
    logic [DISP_W-1:0]  pbest;
    logic [14:0]        val;
    logic [14:0]        alt_lo;
    logic [14:0]        alt_hi;
    logic [14:0]        alt_far;
    logic signed [16:0] raw;
    logic [COST_W-1:0]  result;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign pop = head_valid && (!s1_valid_reg || s1_adv);

    always_comb
    begin
        rd_col = head.col - 1'b1;
        rd_dn = {1'b0, head.disp} + 1'b1;
        even_e = head.disp[0] ? rd_dn : {1'b0, head.disp};
        odd_e = head.disp[0] ? {1'b0, head.disp} : rd_dn;
        even_raddr = {!head.slot, rd_col, even_e[DISP_W-1:1]};
        odd_raddr = {!head.slot, rd_col, odd_e[DISP_W-1:1]};
        stat_raddr = {!head.slot, rd_col};
        cost_waddr = {s1_item_reg.slot, s1_item_reg.col, s1_item_reg.disp[DISP_W-1:1]};
        stat_waddr = {s1_item_reg.slot, s1_item_reg.col};
    end

    sgmdp_ram #(.WIDTH(COST_W), .DEPTH(BANK_DEPTH)) u_even_bank (
        .clk   (clk),
        .we    (s1_adv && !s1_item_reg.disp[0]),
        .waddr (cost_waddr),
        .wdata (result),
        .re    (pop),
        .raddr (even_raddr),
        .rdata (even_q)
    );

    sgmdp_ram #(.WIDTH(COST_W), .DEPTH(BANK_DEPTH)) u_odd_bank (
        .clk   (clk),
        .we    (s1_adv && s1_item_reg.disp[0]),
        .waddr (cost_waddr),
        .wdata (result),
        .re    (pop),
        .raddr (odd_raddr),
        .rdata (odd_q)
    );

    sgmdp_ram #(.WIDTH(STAT_W), .DEPTH(STAT_DEPTH)) u_stat_store (
        .clk   (clk),
        .we    (s1_adv && s1_item_reg.last_pixel),
        .waddr (stat_waddr),
        .wdata (stat_wdata),
        .re    (pop),
        .raddr (stat_raddr),
        .rdata (stat_q)
    );

    always_comb
    begin
        prev_d = s1_item_reg.disp[0] ? odd_q : even_q;
        prev_dp1 = s1_item_reg.disp[0] ? even_q : odd_q;
        pmin = stat_q[STAT_W-1 -: COST_W];
        psec = stat_q[DISP_W +: COST_W];
        pbest = stat_q[DISP_W-1:0];
        alt_lo = {2'b00, prev_dm1_reg} + {7'd0, p1};
        alt_hi = {2'b00, prev_dp1} + {7'd0, p1};
        alt_far = {2'b00, ((s1_item_reg.disp == pbest) ? psec : pmin)} + {3'd0, p2};
        val = {2'b00, prev_d};
        if ((s1_item_reg.disp != '0) && (alt_lo < val))
        begin
            val = alt_lo;
        end
        if (s1_item_reg.has_next && (alt_hi < val))
        begin
            val = alt_hi;
        end
        if (s1_item_reg.multi && (alt_far < val))
        begin
            val = alt_far;
        end
        raw = $signed({9'd0, s1_item_reg.cost}) + $signed({2'b00, val})
            - $signed({4'd0, pmin});
        if (s1_item_reg.first)
        begin
            result = {5'd0, s1_item_reg.cost};
        end
        else if (raw < 0)
        begin
            result = '0;
        end
        else if (raw > $signed({4'd0, COST_ALL_ONES}))
        begin
            result = COST_ALL_ONES;
        end
        else
        begin
            result = raw[COST_W-1:0];
        end
    end

    always_comb
    begin
        run_min_next = run_min_reg;
        run_sec_next = run_sec_reg;
        run_best_next = run_best_reg;
        if (result < run_min_reg)
        begin
            run_sec_next = run_min_reg;
            run_min_next = result;
            run_best_next = s1_item_reg.disp;
        end
        else if (result < run_sec_reg)
        begin
            run_sec_next = result;
        end
        stat_wdata = {run_min_next, run_sec_next, run_best_next};
        if (s1_item_reg.last_pixel)
        begin
            run_min_next = COST_ALL_ONES;
            run_sec_next = COST_ALL_ONES;
            run_best_next = '0;
        end
        s1_valid_next = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_item_reg <= head;
        end
        if (s1_adv)
        begin
            prev_dm1_reg <= prev_d;
            path_cost_reg <= result;
            disparity_reg <= s1_item_reg.disp;
            pixel_row_reg <= s1_item_reg.pix_row;
            pixel_col_reg <= s1_item_reg.pix_col;
            last_pixel_reg <= s1_item_reg.last_pixel;
            last_frame_reg <= s1_item_reg.last_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            run_min_reg <= COST_ALL_ONES;
            run_sec_reg <= COST_ALL_ONES;
            run_best_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                run_min_reg <= run_min_next;
                run_sec_reg <= run_sec_next;
                run_best_reg <= run_best_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign path_cost = path_cost_reg;
    assign disparity = disparity_reg;
    assign pixel_row = pixel_row_reg;
    assign pixel_col = pixel_col_reg;
    assign last_of_pixel = last_pixel_reg;
    assign last_of_frame = last_frame_reg;

endmodule

### dv/sgm_diagonal_path_aggregation_checker.sv
`timescale 1ns / 1ps
// Checker for the diagonal path cost aggregation block: watches the
// configuration port and both channels, predicts each path cost and compares.
// Depends on sgmdp_pkg.
module sgm_diagonal_path_aggregation_checker
    import sgmdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [11:0]       cfg_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [7:0]        match_cost,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [COST_W-1:0] path_cost,
    input  logic [DISP_W-1:0] disparity,
    input  logic [11:0]       pixel_row,
    input  logic [COL_W-1:0]  pixel_col,
    input  logic              last_of_pixel,
    input  logic              last_of_frame,
    output int                fail_count,
    output int                pending_count
);

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [DISP_W-1:0] disp;
        logic [11:0]       row;
        logic [COL_W-1:0]  col;
        logic              last_pixel;
        logic              last_frame;
    } path_result_t;

    path_result_t expected_costs[$];

    logic [7:0]  p1;
    logic [11:0] p2;
    logic [11:0] frame_rows;
    logic [10:0] frame_cols;
    logic [6:0]  disp_count;
    logic        row_down;
    logic        col_right;

    logic [COST_W-1:0] cost_line [0:2*MAX_COLS*MAX_DISP-1];
    logic [COST_W-1:0] min_line [0:2*MAX_COLS-1];
    logic [COST_W-1:0] second_line [0:2*MAX_COLS-1];
    logic [DISP_W-1:0] best_line [0:2*MAX_COLS-1];
    int run_min, run_second, run_best;
    int scan_row, scan_col, scan_disp;

    assign pending_count = expected_costs.size();

    function automatic int bound(int v, int hi);
        if (v < 1) return 1;
        return v > hi ? hi : v;
    endfunction

    function automatic int cost_slot(int slot, int c, int d);
        return (slot * MAX_COLS + (c < MAX_COLS ? c : MAX_COLS - 1)) * MAX_DISP
            + (d < MAX_DISP ? d : MAX_DISP - 1);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic predict_path_cost(input logic [7:0] cost, output path_result_t r);
        int rows, cols, dc, d, slot, ps, pc, pidx, pmin, psec, val, alt, res;
        bit last_pix;
        rows = bound(frame_rows, 4095);
        cols = bound(frame_cols, MAX_COLS);
        dc = bound(disp_count, MAX_DISP);
        d = scan_disp;
        slot = scan_row & 1;
        if (scan_row == 0 || scan_col == 0) begin
            res = cost;
        end else begin
            ps = slot ^ 1;
            pc = scan_col - 1;
            pidx = ps * MAX_COLS + (pc < MAX_COLS ? pc : MAX_COLS - 1);
            pmin = min_line[pidx];
            psec = second_line[pidx];
            val = cost_line[cost_slot(ps, pc, d)];
            if (d > 0) begin
                alt = cost_line[cost_slot(ps, pc, d - 1)] + p1;
                if (alt < val) val = alt;
            end
            if (d + 1 < dc) begin
                alt = cost_line[cost_slot(ps, pc, d + 1)] + p1;
                if (alt < val) val = alt;
            end
            if (dc > 1) begin
                alt = (d == best_line[pidx] ? psec : pmin) + p2;
                if (alt < val) val = alt;
            end
            res = cost + val - pmin;
            if (res < 0) res = 0;
            if (res > 8191) res = 8191;
        end
        cost_line[cost_slot(slot, scan_col, d)] = COST_W'(res);
        if (res < run_min) begin
            run_second = run_min;
            run_min = res;
            run_best = d & 63;
        end else if (res < run_second) begin
            run_second = res;
        end
        last_pix = (d + 1 >= dc);
        r.cost = COST_W'(res);
        r.disp = DISP_W'(d);
        r.row = 12'(row_down ? scan_row : rows - 1 - scan_row);
        r.col = COL_W'(col_right ? scan_col : cols - 1 - scan_col);
        r.last_pixel = last_pix;
        r.last_frame = last_pix && (scan_col + 1 >= cols) && (scan_row + 1 >= rows);
        if (last_pix) begin
            pidx = slot * MAX_COLS + (scan_col < MAX_COLS ? scan_col : MAX_COLS - 1);
            min_line[pidx] = COST_W'(run_min);
            second_line[pidx] = COST_W'(run_second);
            best_line[pidx] = DISP_W'(run_best);
            run_min = 8191;
            run_second = 8191;
            run_best = 0;
            scan_disp = 0;
            if (scan_col + 1 >= cols) begin
                scan_col = 0;
                scan_row = (scan_row + 1 >= rows) ? 0 : scan_row + 1;
            end else begin
                scan_col++;
            end
        end else begin
            scan_disp++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        path_result_t r;
        if (!rst_n) begin
            p1 = 10;
            p2 = 120;
            frame_rows = 480;
            frame_cols = 640;
            disp_count = 64;
            row_down = 1;
            col_right = 1;
            run_min = 8191;
            run_second = 8191;
            run_best = 0;
            scan_row = 0;
            scan_col = 0;
            scan_disp = 0;
            fail_count = 0;
            expected_costs.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_P1:         p1 = cfg_data[7:0];
                    REG_P2:         p2 = cfg_data;
                    REG_FRAME_ROWS: frame_rows = cfg_data;
                    REG_FRAME_COLS: frame_cols = cfg_data[10:0];
                    REG_DISP_COUNT: disp_count = cfg_data[6:0];
                    REG_ROW_DOWN:   row_down = cfg_data[0];
                    REG_COL_RIGHT:  col_right = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_costs.size() == 0) begin
                    $display("%0t: path cost transfer with nothing expected", $time);
                    fail_count++;
                end else begin
                    r = expected_costs.pop_front();
                    if (path_cost !== r.cost) report_mismatch("path_cost", path_cost, r.cost);
                    if (disparity !== r.disp) report_mismatch("disparity", disparity, r.disp);
                    if (pixel_row !== r.row) report_mismatch("pixel_row", pixel_row, r.row);
                    if (pixel_col !== r.col) report_mismatch("pixel_col", pixel_col, r.col);
                    if (last_of_pixel !== r.last_pixel)
                        report_mismatch("last_of_pixel", last_of_pixel, r.last_pixel);
                    if (last_of_frame !== r.last_frame)
                        report_mismatch("last_of_frame", last_of_frame, r.last_frame);
                end
            end
            if (in_valid && !in_stall) begin
                predict_path_cost(match_cost, r);
                expected_costs.push_back(r);
            end
        end
    end

endmodule

### dv/sgm_diagonal_path_aggregation_core_test.sv
`timescale 1ns / 1ps
// Top of the regression for the diagonal path cost aggregation block: drives
// configuration, costs and output stalls, and gives the verdict.
// Depends on sgmdp_pkg, the block and sgm_diagonal_path_aggregation_checker.
module sgm_diagonal_path_aggregation_core_test;
    import sgmdp_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [2:0] cfg_index = REG_P1;
    logic [11:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [7:0] match_cost = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [COST_W-1:0] path_cost;
    logic [DISP_W-1:0] disparity;
    logic [11:0] pixel_row;
    logic [COL_W-1:0] pixel_col;
    logic last_of_pixel;
    logic last_of_frame;
    int fail_count;
    int pending_count;
    int sent_costs = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    bit hold_req = 0;

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    sgm_diagonal_path_aggregation_core dut (.*);

    sgm_diagonal_path_aggregation_checker checker_i (.*);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("sgm_diagonal_path_aggregation_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        bit v;
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_req) begin
                hold_req = 0;
                v = 1;
                n = 300;
            end else if (quiet) begin
                v = 0;
                n = 1;
            end else if ($urandom_range(0, 7) == 0) begin
                v = 0;
                n = $urandom_range(20, 60);
            end else begin
                v = ($urandom_range(0, 2) == 0);
                n = $urandom_range(1, 7);
            end
            out_stall <= v;
            repeat (n) @(posedge clk);
        end
    end

    task automatic send_cost(input logic [7:0] cost);
        in_valid <= 1;
        match_cost <= cost;
        do @(posedge clk); while (in_stall);
        sent_costs++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic run_frame(input int p1, input int p2, input int rows, input int cols,
                             input int disps, input bit down, input bit right,
                             input bit extremes);
        logic [11:0] vals[7];
        int n;
        in_valid <= 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        vals = '{p1, p2, rows, cols, disps, down, right};
        for (int i = 0; i < 7; i++) begin
            cfg_we <= 1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 0;
        n = (rows < 1 ? 1 : rows) * (cols < 1 ? 1 : cols > MAX_COLS ? MAX_COLS : cols)
            * (disps < 1 ? 1 : disps > MAX_DISP ? MAX_DISP : disps);
        for (int i = 0; i < n; i++)
            send_cost(extremes ? ((i % 3 == 0) ? 8'd255 : 8'd0) : 8'($urandom));
    endtask

    initial
    begin
        int rows, cols, disps;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        run_frame(10, 120, 3, 3, 2, 1, 1, 1);
        run_frame(0, 0, 2, 3, 1, 0, 0, 1);
        hold_req = 1;
        run_frame($urandom_range(0, 255), $urandom_range(0, 4095), 6, 8, 8, 1, 0, 0);
        run_frame(255, 4095, 2, 2, 127, 0, 1, 0);
        run_frame(0, 0, 0, 0, 0, 1, 1, 0);
        while (sent_costs < 876)
        begin
            rows = $urandom_range(1, 6);
            cols = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            disps = $urandom_range(0, 10);
            if ($urandom_range(0, 9) == 0) begin
                rows = $urandom_range(1, 3);
                cols = $urandom_range(1, 3);
                disps = 64;
            end
            run_frame(($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 60),
                      ($urandom_range(0, 5) == 0) ? 4095 : $urandom_range(0, 300),
                      rows, cols, disps, $urandom_range(0, 1), $urandom_range(0, 1), 0);
        end
        quiet = 1;
        run_frame(30, 200, 1, 2047, 1, 1, 0, 0);
        in_valid <= 0;
        while (pending_count != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("sgm_diagonal_path_aggregation_core regression: pass");
        else
            $display("sgm_diagonal_path_aggregation_core regression: fail");
        $finish;
    end

endmodule
